// File: rtl/pdh_pkg.sv
// ----------------------------------------------------------------------------
// pdh_pkg: shared types and constants
// Field widths, parameter defaults and the command codes passed from the
// classifier front end to the histogram back end.
// ----------------------------------------------------------------------------
`default_nettype none

package pdh_pkg;

    // fixed field widths of the stream beats
    localparam int unsigned FUNC_W   = 1;
    localparam int unsigned MODREQ_W = 4;
    localparam int unsigned SAMPLE_W = 12;
    localparam int unsigned RBIN_W   = 13;
    localparam int unsigned OUT_W    = 32;

    // parameter defaults
    localparam int unsigned MODULES_DEF    = 16;
    localparam int unsigned HALF_BINS_DEF  = 4096;
    localparam int unsigned COUNT_BITS_DEF = 32;

    // func codes
    localparam logic [FUNC_W-1:0] FUNC_ACC  = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_READ = 1'b1;

    // classified command kind
    typedef enum logic [1:0] {
        K_NULL = 2'd0,   // no memory access, result all zero
        K_READ = 2'd1,   // read one bin
        K_ACC  = 2'd2    // increment one bin
    } t_kind;

    // head of the command queue, seen by the back end
    typedef struct packed {
        logic  valid;
        t_kind kind;
    } t_qhead;

endpackage

`default_nettype wire

// File: rtl/pdh_ram.sv
// ----------------------------------------------------------------------------
// pdh_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pdh_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  wire                     i_clk,
    input  wire                     i_wr_en,
    input  wire [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire [WIDTH-1:0]         i_wr_data,
    input  wire                     i_rd_en,
    input  wire [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]        o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/pdh_front.sv
// ----------------------------------------------------------------------------
// pdh_front: item classifier and command queue
// Gates the sample pair, forms the bin address and queues one command per
// accepted beat for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module pdh_front #(
    parameter int unsigned MODULES   = pdh_pkg::MODULES_DEF,
    parameter int unsigned HALF_BINS = pdh_pkg::HALF_BINS_DEF,
    parameter int unsigned ADDR_W    = 17
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_valid,
    output logic                               o_ready,
    input  wire [pdh_pkg::FUNC_W-1:0]          i_func,
    input  wire [pdh_pkg::MODREQ_W-1:0]        i_module,
    input  wire [pdh_pkg::SAMPLE_W-1:0]        i_first,
    input  wire [pdh_pkg::SAMPLE_W-1:0]        i_second,
    input  wire [pdh_pkg::RBIN_W-1:0]          i_rbin,
    input  wire                                i_clr_done,
    input  wire                                i_pop,
    output pdh_pkg::t_qhead                    o_head,
    output logic [ADDR_W-1:0]                  o_head_addr
);

    import pdh_pkg::*;

    localparam int unsigned BINS   = 2 * HALF_BINS;
    localparam int unsigned DIFF_W = $clog2(HALF_BINS + (2 ** SAMPLE_W)) + 1;
    localparam int unsigned QDEPTH = 2;
    localparam int unsigned PTR_W  = $clog2(QDEPTH);
    localparam int unsigned CNT_W  = $clog2(QDEPTH + 1);

    logic [DIFF_W-1:0] diff;
    logic              mod_ok;
    logic              acc_ok;
    logic              rd_ok;
    logic [31:0]       bin;
    t_kind             kind;
    logic [ADDR_W-1:0] addr;
    logic              push;

    t_kind             r_q_kind [QDEPTH];
    logic [ADDR_W-1:0] r_q_addr [QDEPTH];
    logic [PTR_W-1:0]  r_wptr;
    logic [PTR_W-1:0]  r_rptr;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;

    // classify: first - second + HALF_BINS, sign bit marks an underflow
    always_comb begin
        diff   = DIFF_W'(i_first) + DIFF_W'(HALF_BINS) - DIFF_W'(i_second);
        mod_ok = 32'(i_module) < 32'(MODULES);
        acc_ok = ((i_first & i_second) != '0) && !diff[DIFF_W-1]
                 && (32'(diff) < 32'(BINS));
        rd_ok  = 32'(i_rbin) < 32'(BINS);
        bin    = (i_func == FUNC_READ) ? 32'(i_rbin) : 32'(diff);
        if (!mod_ok) begin
            kind = K_NULL;
        end else if (i_func == FUNC_READ) begin
            kind = rd_ok ? K_READ : K_NULL;
        end else begin
            kind = acc_ok ? K_ACC : K_NULL;
        end
        addr = ADDR_W'(32'(i_module) * 32'(BINS) + bin);
    end

    assign o_ready = (r_count != CNT_W'(QDEPTH)) && i_clr_done;
    assign push    = i_valid && o_ready;

    always_comb begin
        n_count = r_count;
        if (push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (push) begin
                r_wptr <= (32'(r_wptr) == QDEPTH - 1) ? '0 : r_wptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= (32'(r_rptr) == QDEPTH - 1) ? '0 : r_rptr + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_kind[r_wptr] <= kind;
            r_q_addr[r_wptr] <= addr;
        end
    end

    assign o_head.valid = r_count != '0;
    assign o_head.kind  = r_q_kind[r_rptr];
    assign o_head_addr  = r_q_addr[r_rptr];

endmodule

`default_nettype wire

// File: rtl/pdh_back.sv
// ----------------------------------------------------------------------------
// pdh_back: histogram sequencer
// Clears the count store after reset, then runs one read (plus a write for an
// accumulate) per queued bin command and holds the result beat in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pdh_back #(
    parameter int unsigned COUNT_BITS = pdh_pkg::COUNT_BITS_DEF,
    parameter int unsigned DEPTH      = 131072,
    parameter int unsigned ADDR_W     = 17
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire pdh_pkg::t_qhead     i_head,
    input  wire [ADDR_W-1:0]         i_head_addr,
    output logic                     o_pop,
    output logic                     o_clr_done,
    output logic                     o_wr_en,
    output logic [ADDR_W-1:0]        o_wr_addr,
    output logic [COUNT_BITS-1:0]    o_wr_data,
    output logic                     o_rd_en,
    output logic [ADDR_W-1:0]        o_rd_addr,
    input  wire [COUNT_BITS-1:0]     i_rd_data,
    input  wire                      i_m_tready,
    output logic                     o_m_tvalid,
    output logic                     o_counted,
    output logic                     o_saturated,
    output logic [pdh_pkg::OUT_W-1:0] o_count
);

    import pdh_pkg::*;

    localparam logic [COUNT_BITS-1:0] CMAX = '1;

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_WAIT  = 3'b100
    } t_state;

    t_state             r_state;
    t_state             n_state;
    logic [ADDR_W-1:0]  r_clr_addr;
    t_kind              r_kind;
    logic [ADDR_W-1:0]  r_addr;
    logic               r_out_valid;
    logic               r_counted;
    logic               r_sat;
    logic [OUT_W-1:0]   r_count;
    logic               out_free;
    logic               is_max;
    logic [COUNT_BITS-1:0] inc;

    assign out_free   = !r_out_valid || i_m_tready;
    assign o_pop      = (r_state == S_IDLE) && i_head.valid && out_free;
    assign o_rd_en    = o_pop && (i_head.kind != K_NULL);
    assign o_rd_addr  = i_head_addr;
    assign o_clr_done = r_state != S_CLEAR;
    assign is_max     = i_rd_data == CMAX;
    assign inc        = i_rd_data + COUNT_BITS'(1);

    always_comb begin
        o_wr_en   = 1'b0;
        o_wr_addr = r_addr;
        o_wr_data = inc;
        case (r_state)
            S_CLEAR: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_clr_addr;
                o_wr_data = '0;
            end
            S_WAIT: begin
                o_wr_en = (r_kind == K_ACC) && !is_max;
            end
            default: begin
                o_wr_en = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (32'(r_clr_addr) == DEPTH - 1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (o_rd_en) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
            // a new result takes priority over the drain of the old one
            if ((o_pop && (i_head.kind == K_NULL)) || (r_state == S_WAIT)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_kind    <= i_head.kind;
            r_addr    <= i_head_addr;
            r_counted <= 1'b0;
            r_sat     <= 1'b0;
            r_count   <= '0;
        end
        if (r_state == S_WAIT) begin
            if (r_kind == K_ACC && !is_max) begin
                r_counted <= 1'b1;
                r_sat     <= 1'b0;
                r_count   <= OUT_W'(inc);
            end else begin
                r_counted <= 1'b0;
                r_sat     <= is_max;
                r_count   <= OUT_W'(i_rd_data);
            end
        end
    end

    assign o_m_tvalid  = r_out_valid;
    assign o_counted   = r_counted;
    assign o_saturated = r_sat;
    assign o_count     = r_count;

    a_no_pop_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_pop)
        else $error("command popped during clearing pass");

    a_wait_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WAIT) |-> !r_out_valid)
        else $error("result register busy while a read completes");

    a_mem_pop_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rd_en |=> (r_state == S_WAIT))
        else $error("memory command did not enter the update step");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_counted && r_sat))
        else $error("counted and saturated both set");

endmodule

`default_nettype wire

// File: rtl/pair_difference_histogram_top.sv
// ----------------------------------------------------------------------------
// pair_difference_histogram_top: per-module sample-pair difference histogram
// Accumulates first-minus-second differences of gated sample pairs into one
// histogram per module and reads single bins back.
// ----------------------------------------------------------------------------
// After reset the block sweeps all MODULES * 2 * HALF_BINS entries of the count
// store to zero, one entry per cycle (131072 entries at the defaults);
// s_axis_tready stays low until the sweep ends. Each beat then yields exactly
// one result beat in order. A beat that touches no bin (gate fails, module or
// bin out of range) has its result registered when popped; an accumulate or
// read reads the bin from the count RAM, then in S_WAIT registers the result,
// and an accumulate below the maximum writes the count back incremented. No
// command is popped in S_WAIT. A two-deep command queue from the classifier
// feeds the sequencer, which pops only if the result register is empty or drains.
// ----------------------------------------------------------------------------
`default_nettype none

module pair_difference_histogram_top #(
    parameter int unsigned MODULES    = pdh_pkg::MODULES_DEF,
    parameter int unsigned HALF_BINS  = pdh_pkg::HALF_BINS_DEF,
    parameter int unsigned COUNT_BITS = pdh_pkg::COUNT_BITS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // input beats
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // [3:0] module_req, [15:4] sample_first, [27:16] sample_second,
    // [40:28] read_bin, [47:41] zero
    input  wire [47:0]  s_axis_tdata,
    // [0] func: 0 accumulate, 1 read
    input  wire         s_axis_tuser,
    // result beats
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // [31:0] bin_count
    output logic [31:0] m_axis_tdata,
    // [0] counted, [1] saturated
    output logic [1:0]  m_axis_tuser
);

    import pdh_pkg::*;

    localparam int unsigned DEPTH  = MODULES * 2 * HALF_BINS;
    localparam int unsigned ADDR_W = $clog2(DEPTH);

    t_qhead                head;
    logic [ADDR_W-1:0]     head_addr;
    logic                  pop;
    logic                  clr_done;
    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr;
    logic [COUNT_BITS-1:0] wr_data;
    logic                  rd_en;
    logic [ADDR_W-1:0]     rd_addr;
    logic [COUNT_BITS-1:0] rd_data;
    logic                  counted;
    logic                  saturated;

    // classifier and command queue
    pdh_front #(
        .MODULES   (MODULES),
        .HALF_BINS (HALF_BINS),
        .ADDR_W    (ADDR_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_func      (s_axis_tuser),
        .i_module    (s_axis_tdata[3:0]),
        .i_first     (s_axis_tdata[15:4]),
        .i_second    (s_axis_tdata[27:16]),
        .i_rbin      (s_axis_tdata[40:28]),
        .i_clr_done  (clr_done),
        .i_pop       (pop),
        .o_head      (head),
        .o_head_addr (head_addr)
    );

    // read-modify-write sequencer and result register
    pdh_back #(
        .COUNT_BITS (COUNT_BITS),
        .DEPTH      (DEPTH),
        .ADDR_W     (ADDR_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_head_addr (head_addr),
        .o_pop       (pop),
        .o_clr_done  (clr_done),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .i_m_tready  (m_axis_tready),
        .o_m_tvalid  (m_axis_tvalid),
        .o_counted   (counted),
        .o_saturated (saturated),
        .o_count     (m_axis_tdata)
    );

    // count store, all modules back to back
    pdh_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (DEPTH)
    ) u_counts (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign m_axis_tuser = {saturated, counted};

endmodule

`default_nettype wire
